>>> src/bmpk_pkg.sv
// Package for the BMP pixel to RGBA keyer.
// Holds the register map, the format codes and the configuration and job types.
// No dependencies.
package bmpk_pkg;

   localparam logic [1:0] FMT_PALETTE = 2'd0;
   localparam logic [1:0] FMT_BGR     = 2'd1;
   localparam logic [1:0] FMT_BGRA    = 2'd2;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd1;
   localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd2;
   localparam logic [2:0] REG_ROW_STRIDE     = 3'd3;
   localparam logic [2:0] REG_PALETTE_ZERO   = 3'd4;
   localparam logic [2:0] REG_PALETTE_ONE    = 3'd5;
   localparam logic [2:0] REG_SINGLE_ENTRY   = 3'd6;
   localparam logic [2:0] REG_WHITE_THRESH   = 3'd7;

   localparam logic [12:0] MAX_WIDTH  = 13'd4096;
   localparam logic [12:0] MAX_HEIGHT = 13'd4096;
   localparam logic [14:0] STRIDE_CAP = 15'd16384;

   // floor(pos / 3) == (pos * DIV3_RECIP) >> DIV3_SHIFT for every 14-bit pos.
   localparam logic [14:0] DIV3_RECIP = 15'd21846;
   localparam int          DIV3_SHIFT = 16;

   typedef struct packed {
      logic [1:0]  pixel_format;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [14:0] row_stride_bytes;
      logic [23:0] palette_color_zero;
      logic [23:0] palette_color_one;
      logic        single_entry_palette;
      logic [7:0]  white_threshold;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        palette;
      logic        copy_alpha;
      logic [7:0]  src_byte;
      logic [23:0] rgb;
      logic [11:0] drow;
      logic [11:0] col;
      logic [2:0]  last_idx;
   } job_type;

endpackage

>>> src/bmpk_csr.sv
// Configuration registers of the BMP pixel to RGBA keyer behind an APB-style port.
// Depends on bmpk_pkg.
module bmpk_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bmpk_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output bmpk_pkg::cfg_type                cfg
);
   import bmpk_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_PIXEL_FORMAT: cfg_in.pixel_format         = pwdata[1:0];
            REG_IMAGE_WIDTH:  cfg_in.image_width          = pwdata[12:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height         = pwdata[12:0];
            REG_ROW_STRIDE:   cfg_in.row_stride_bytes     = pwdata[14:0];
            REG_PALETTE_ZERO: cfg_in.palette_color_zero   = pwdata[23:0];
            REG_PALETTE_ONE:  cfg_in.palette_color_one    = pwdata[23:0];
            REG_SINGLE_ENTRY: cfg_in.single_entry_palette = pwdata[0];
            REG_WHITE_THRESH: cfg_in.white_threshold      = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_PIXEL_FORMAT: prdata = {30'd0, cfg_ff.pixel_format};
         REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_ff.image_width};
         REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_ff.image_height};
         REG_ROW_STRIDE:   prdata = {17'd0, cfg_ff.row_stride_bytes};
         REG_PALETTE_ZERO: prdata = {8'd0, cfg_ff.palette_color_zero};
         REG_PALETTE_ONE:  prdata = {8'd0, cfg_ff.palette_color_one};
         REG_SINGLE_ENTRY: prdata = {31'd0, cfg_ff.single_entry_palette};
         REG_WHITE_THRESH: prdata = {24'd0, cfg_ff.white_threshold};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format         <= FMT_BGR;
         cfg_ff.image_width          <= 13'd640;
         cfg_ff.image_height         <= 13'd480;
         cfg_ff.row_stride_bytes     <= 15'd1920;
         cfg_ff.palette_color_zero   <= 24'h000000;
         cfg_ff.palette_color_one    <= 24'hFFFFFF;
         cfg_ff.single_entry_palette <= 1'b0;
         cfg_ff.white_threshold      <= 8'd240;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/bmpk_decode.sv
// Byte decoder of the BMP pixel to RGBA keyer: row position, source row and channel
// gathering, and the pixel job that each accepted byte produces. Depends on bmpk_pkg.
module bmpk_decode (
   input  logic              clock,
   input  logic              reset,
   input  bmpk_pkg::cfg_type cfg,
   input  logic              accept,
   input  logic [7:0]        pixel_byte,
   output bmpk_pkg::job_type job
);
   import bmpk_pkg::*;

   logic [13:0] row_byte_pos_ff, row_byte_pos_in;
   logic [11:0] source_row_ff, source_row_in;
   logic [23:0] channel_hold_ff, channel_hold_in;
   logic [1:0]  channel_phase_ff, channel_phase_in;

   logic [12:0] w;
   logic [12:0] h_nz;
   logic [12:0] h;
   logic [14:0] stride;
   logic [11:0] y;
   logic [11:0] f;
   logic [12:0] h_plus;
   logic [11:0] drow;
   logic [14:0] pos_next;
   logic        row_end;
   logic [12:0] row_next;
   logic [16:0] col_base;
   logic        pal_has;
   logic [12:0] pal_rem;
   logic [12:0] pal_rem_m1;
   logic [28:0] div3_prod;
   logic [12:0] div3;
   logic [11:0] div4;
   logic [23:0] hold_merged;

   assign w        = (cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : cfg.image_width;
   assign h_nz     = (cfg.image_height == 13'd0) ? 13'd1 : cfg.image_height;
   assign h        = (h_nz > MAX_HEIGHT) ? MAX_HEIGHT : h_nz;
   assign stride   = (cfg.row_stride_bytes > STRIDE_CAP) ? STRIDE_CAP : cfg.row_stride_bytes;
   assign y        = ({1'b0, source_row_ff} < h) ? source_row_ff : 12'(h - 13'd1);
   assign f        = 12'(h - 13'd1 - {1'b0, y});
   assign h_plus   = h + 13'd1;
   assign drow     = f[0] ? (h_plus[12:1] + {1'b0, f[11:1]}) : {1'b0, f[11:1]};

   assign pos_next = {1'b0, row_byte_pos_ff} + 15'd1;
   assign row_end  = pos_next >= stride;
   assign row_next = {1'b0, source_row_ff} + 13'd1;

   assign col_base   = {row_byte_pos_ff, 3'b000};
   assign pal_has    = col_base < {4'd0, w};
   assign pal_rem    = w - {1'b0, col_base[11:0]};
   assign pal_rem_m1 = pal_rem - 13'd1;

   assign div3_prod = 29'(row_byte_pos_ff) * 29'(DIV3_RECIP);
   assign div3      = div3_prod[28:DIV3_SHIFT];
   assign div4      = row_byte_pos_ff[13:2];

   always_comb begin
      case (channel_phase_ff)
         2'd0:    hold_merged = channel_hold_ff | {16'd0, pixel_byte};
         2'd1:    hold_merged = channel_hold_ff | {8'd0, pixel_byte, 8'd0};
         2'd2:    hold_merged = channel_hold_ff | {pixel_byte, 16'd0};
         default: hold_merged = channel_hold_ff;
      endcase
   end

   always_comb begin
      job.valid      = 1'b0;
      job.palette    = 1'b0;
      job.copy_alpha = 1'b0;
      job.src_byte   = pixel_byte;
      job.rgb        = channel_hold_ff;
      job.drow       = drow;
      job.col        = div4;
      job.last_idx   = 3'd0;
      channel_phase_in = channel_phase_ff;
      channel_hold_in  = channel_hold_ff;
      case (cfg.pixel_format)
         FMT_PALETTE: begin
            job.valid    = pal_has;
            job.palette  = 1'b1;
            job.col      = col_base[11:0];
            job.last_idx = (pal_rem > 13'd8) ? 3'd7 : pal_rem_m1[2:0];
         end
         FMT_BGR: begin
            if (channel_phase_ff >= 2'd2) begin
               job.valid        = div3 < w;
               job.rgb          = hold_merged;
               job.col          = div3[11:0];
               channel_phase_in = 2'd0;
               channel_hold_in  = 24'd0;
            end else begin
               channel_hold_in  = hold_merged;
               channel_phase_in = channel_phase_ff + 2'd1;
            end
         end
         FMT_BGRA: begin
            if (channel_phase_ff == 2'd3) begin
               job.valid        = {1'b0, div4} < w;
               job.copy_alpha   = 1'b1;
               channel_phase_in = 2'd0;
               channel_hold_in  = 24'd0;
            end else begin
               channel_hold_in  = hold_merged;
               channel_phase_in = channel_phase_ff + 2'd1;
            end
         end
         default: begin
            job.valid = 1'b0;
         end
      endcase
      if (row_end) begin
         row_byte_pos_in  = 14'd0;
         channel_phase_in = 2'd0;
         channel_hold_in  = 24'd0;
         source_row_in    = (row_next >= h) ? 12'd0 : row_next[11:0];
      end else begin
         row_byte_pos_in  = pos_next[13:0];
         source_row_in    = source_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_byte_pos_ff  <= 14'd0;
         source_row_ff    <= 12'd0;
         channel_hold_ff  <= 24'd0;
         channel_phase_ff <= 2'd0;
      end else if (accept) begin
         row_byte_pos_ff  <= row_byte_pos_in;
         source_row_ff    <= source_row_in;
         channel_hold_ff  <= channel_hold_in;
         channel_phase_ff <= channel_phase_in;
      end
   end

endmodule

>>> src/bmp_pixel_to_rgba_keyer.sv
// Top level of the BMP pixel to RGBA keyer: byte input, pixel job register and result register.
// Depends on bmpk_pkg, bmpk_csr and bmpk_decode.
//
// The block takes the pixel array of a bottom-up BMP image one byte per transaction and
// returns RGBA pixels with their column and destination row (flipped, then interlaced even
// rows first). Each pixel passes the job register and then the result register, and a result
// stall holds both. In 24-bit and 32-bit modes it accepts one byte per cycle and returns at
// most one pixel per byte. In one-bit palette mode a byte yields up to eight pixels, which
// leave through the single result register one per cycle, so such a byte holds the input until
// its last pixel has left. Registers may be written only while no transaction is in flight.
module bmp_pixel_to_rgba_keyer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_pixel_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   output logic [7:0]                       rsp_alpha,
   output logic [11:0]                      rsp_dest_row,
   output logic [11:0]                      rsp_column,
   output logic                             rsp_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bmpk_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import bmpk_pkg::*;

   cfg_type     cfg;
   job_type     new_job;
   job_type     job_ff, job_in;
   logic [2:0]  slot_ff, slot_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_rgb_ff, rsp_rgb_in;
   logic [7:0]  rsp_alpha_ff, rsp_alpha_in;
   logic [11:0] rsp_row_ff, rsp_row_in;
   logic [11:0] rsp_col_ff, rsp_col_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        accept;
   logic        emit_fire;
   logic        emit_last;
   logic        emit_done;
   logic        pal_bit;
   logic [23:0] emit_rgb;
   logic        keyed;

   assign pready = 1'b1;

   bmpk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   bmpk_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .pixel_byte (req_pixel_byte),
      .job        (new_job)
   );

   assign emit_fire = job_ff.valid && (!rsp_valid_ff || rsp_ready);
   assign emit_last = slot_ff == job_ff.last_idx;
   assign emit_done = emit_fire && emit_last;
   assign req_ready = !job_ff.valid || emit_done;
   assign accept    = req_valid && req_ready;

   assign pal_bit  = job_ff.src_byte[3'd7 - slot_ff];
   assign emit_rgb = !job_ff.palette ? job_ff.rgb :
                     (pal_bit && !cfg.single_entry_palette) ? cfg.palette_color_one :
                                                             cfg.palette_color_zero;
   assign keyed    = (emit_rgb[23:16] > cfg.white_threshold) &&
                     (emit_rgb[15:8]  > cfg.white_threshold) &&
                     (emit_rgb[7:0]   > cfg.white_threshold);

   always_comb begin
      job_in  = job_ff;
      slot_in = slot_ff;
      if (accept) begin
         job_in  = new_job;
         slot_in = 3'd0;
      end else if (emit_done) begin
         job_in.valid = 1'b0;
      end else if (emit_fire) begin
         slot_in = slot_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_rgb_in   = emit_rgb;
         rsp_alpha_in = job_ff.copy_alpha ? job_ff.src_byte : (keyed ? 8'd0 : 8'd255);
         rsp_row_in   = job_ff.drow;
         rsp_col_in   = job_ff.col + {9'd0, slot_ff};
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff       <= '0;
         slot_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_ff       <= job_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rgb_ff        <= rsp_rgb_in;
      rsp_alpha_ff      <= rsp_alpha_in;
      rsp_row_ff        <= rsp_row_in;
      rsp_col_ff        <= rsp_col_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_red      = rsp_rgb_ff[23:16];
   assign rsp_green    = rsp_rgb_ff[15:8];
   assign rsp_blue     = rsp_rgb_ff[7:0];
   assign rsp_alpha    = rsp_alpha_ff;
   assign rsp_dest_row = rsp_row_ff;
   assign rsp_column   = rsp_col_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> sim/bmp_pixel_to_rgba_keyer_tb.sv
// Self-checking testbench for the BMP pixel to RGBA keyer: directed and random byte streams.
// A local pixel predictor checks each result transaction; depends on bmpk_pkg and the top level.
// Registers are reprogrammed over the APB port between phases, only while the block is idle.
`timescale 1ns / 1ps

module bmp_pixel_to_rgba_keyer_tb;
   import bmpk_pkg::*;

   localparam logic [1:0] FMT_UNUSED   = 2'd3;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         SETTLE       = 12;
   localparam int         RANDOM_BYTES = 280;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] dest_row;
      logic [11:0] column;
      logic        last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_pixel_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_red;
   logic [7:0]            rsp_green;
   logic [7:0]            rsp_blue;
   logic [7:0]            rsp_alpha;
   logic [11:0]           rsp_dest_row;
   logic [11:0]           rsp_column;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = 32'h0;
   logic [31:0]           prdata;
   logic                  pready;

   cfg_type     shadow;
   int unsigned row_pos;
   int unsigned src_row;
   logic [23:0] hold;
   logic [1:0]  phase_idx;

   logic [7:0]  byte_queue [$];
   pixel_type   pixels_due [$];
   pixel_type   due_pixel;
   int unsigned bytes_queued = 0;
   int unsigned bytes_sent = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic        byte_taken = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   logic [7:0]  ready_pattern = 8'hFF;
   int unsigned ready_count = 0;

   bmp_pixel_to_rgba_keyer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_byte (req_pixel_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_dest_row   (rsp_dest_row),
      .rsp_column     (rsp_column),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] key_alpha(input logic [23:0] rgb);
      if (rgb[23:16] > shadow.white_threshold && rgb[15:8] > shadow.white_threshold &&
          rgb[7:0] > shadow.white_threshold) begin
         return ALPHA_CLEAR;
      end
      return ALPHA_OPAQUE;
   endfunction

   function automatic pixel_type make_pixel(input logic [23:0] rgb, input logic [7:0] a,
                                            input int unsigned drow, input int unsigned col);
      pixel_type p;
      p.red      = rgb[23:16];
      p.green    = rgb[15:8];
      p.blue     = rgb[7:0];
      p.alpha    = a;
      p.dest_row = drow[11:0];
      p.column   = col[11:0];
      p.last     = 1'b0;
      return p;
   endfunction

   function automatic void convert_byte(input logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned stride;
      int unsigned y;
      int unsigned f;
      int unsigned drow;
      int unsigned col;
      int          n;
      logic [23:0] rgb;
      logic [31:0] merged;
      pixel_type   burst [8];
      w = (shadow.image_width > MAX_WIDTH) ? MAX_WIDTH : shadow.image_width;
      h = (shadow.image_height == 0) ? 1 : shadow.image_height;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      stride = (shadow.row_stride_bytes > STRIDE_CAP) ? STRIDE_CAP : shadow.row_stride_bytes;
      y = (src_row < h) ? src_row : h - 1;
      f = h - 1 - y;
      drow = f[0] ? ((h + 1) >> 1) + ((f - 1) >> 1) : (f >> 1);
      n = 0;
      case (shadow.pixel_format)
         FMT_PALETTE: begin
            for (int k = 0; k < 8; k++) begin
               col = row_pos * 8 + k;
               if (col < w) begin
                  rgb = (b[7 - k] && !shadow.single_entry_palette) ?
                        shadow.palette_color_one : shadow.palette_color_zero;
                  burst[n] = make_pixel(rgb, key_alpha(rgb), drow, col);
                  n++;
               end
            end
         end
         FMT_BGR: begin
            merged = {8'h00, hold} | ({24'h0, b} << (8 * phase_idx));
            hold = merged[23:0];
            if (phase_idx >= 2) begin
               col = row_pos / 3;
               if (col < w) begin
                  burst[n] = make_pixel(hold, key_alpha(hold), drow, col);
                  n++;
               end
               phase_idx = 0;
               hold = 24'h0;
            end else begin
               phase_idx++;
            end
         end
         FMT_BGRA: begin
            if (phase_idx >= 3) begin
               col = row_pos / 4;
               if (col < w) begin
                  burst[n] = make_pixel(hold, b, drow, col);
                  n++;
               end
               phase_idx = 0;
               hold = 24'h0;
            end else begin
               merged = {8'h00, hold} | ({24'h0, b} << (8 * phase_idx));
               hold = merged[23:0];
               phase_idx++;
            end
         end
         default: ;
      endcase
      if (row_pos + 1 >= stride) begin
         row_pos = 0;
         phase_idx = 0;
         hold = 24'h0;
         src_row = (src_row + 1 >= h) ? 0 : ((src_row + 1) & 32'hFFF);
      end else begin
         row_pos = (row_pos + 1) & 32'h3FFF;
      end
      if (n > 0) burst[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) pixels_due.push_back(burst[i]);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_PIXEL_FORMAT: shadow.pixel_format         = value[1:0];
         REG_IMAGE_WIDTH:  shadow.image_width          = value[12:0];
         REG_IMAGE_HEIGHT: shadow.image_height         = value[12:0];
         REG_ROW_STRIDE:   shadow.row_stride_bytes     = value[14:0];
         REG_PALETTE_ZERO: shadow.palette_color_zero   = value[23:0];
         REG_PALETTE_ONE:  shadow.palette_color_one    = value[23:0];
         REG_SINGLE_ENTRY: shadow.single_entry_palette = value[0];
         REG_WHITE_THRESH: shadow.white_threshold      = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      do @(negedge clock); while (bytes_sent != bytes_queued || pixels_due.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic configure(input logic [1:0] fmt, input logic [12:0] w, input logic [12:0] h,
                            input logic [14:0] stride, input logic [23:0] p0,
                            input logic [23:0] p1, input logic one_entry,
                            input logic [7:0] thr);
      wait_drain();
      write_reg(REG_PIXEL_FORMAT, 32'(fmt));
      write_reg(REG_IMAGE_WIDTH, 32'(w));
      write_reg(REG_IMAGE_HEIGHT, 32'(h));
      write_reg(REG_ROW_STRIDE, 32'(stride));
      write_reg(REG_PALETTE_ZERO, 32'(p0));
      write_reg(REG_PALETTE_ONE, 32'(p1));
      write_reg(REG_SINGLE_ENTRY, 32'(one_entry));
      write_reg(REG_WHITE_THRESH, 32'(thr));
   endtask

   task automatic send_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !byte_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left  <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
         req_valid      <= 1'b1;
         req_pixel_byte <= byte_queue.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (ready_count == 0) begin
         ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         ready_count   <= $urandom_range(16, 80);
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
         ready_count   <= ready_count - 1;
      end
      rsp_ready <= ready_pattern[0];
   end

   always @(posedge clock) begin
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         byte_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            convert_byte(req_pixel_byte);
            bytes_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               $error("Result transaction with no pixel due: row %0d column %0d",
                      rsp_dest_row, rsp_column);
               error_count++;
            end else begin
               due_pixel = pixels_due.pop_front();
               check_field("red", due_pixel.red, rsp_red);
               check_field("green", due_pixel.green, rsp_green);
               check_field("blue", due_pixel.blue, rsp_blue);
               check_field("alpha", due_pixel.alpha, rsp_alpha);
               check_field("dest_row", due_pixel.dest_row, rsp_dest_row);
               check_field("column", due_pixel.column, rsp_column);
               check_field("last", due_pixel.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned random_bytes;
      int unsigned phase_no;
      int unsigned n;
      int unsigned sel;
      logic [1:0]  fmt;
      logic [12:0] w;
      logic [12:0] h;
      logic [14:0] stride;
      logic [23:0] p0;
      logic [23:0] p1;
      logic        one_entry;
      logic [7:0]  thr;

      random_bytes = 0;
      phase_no = 0;
      shadow.pixel_format = FMT_BGR;
      shadow.image_width = 13'd640;
      shadow.image_height = 13'd480;
      shadow.row_stride_bytes = 15'd1920;
      shadow.palette_color_zero = 24'h000000;
      shadow.palette_color_one = 24'hFFFFFF;
      shadow.single_entry_palette = 1'b0;
      shadow.white_threshold = 8'd240;
      row_pos = 0;
      src_row = 0;
      hold = 24'h0;
      phase_idx = 2'd0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: white keyed, dark opaque, channels equal to the threshold stay opaque.
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'h00); send_byte(8'h80); send_byte(8'hFF);
      send_byte(8'hF0); send_byte(8'hF1); send_byte(8'hF1);

      // Palette with bits past the width and padding bytes, then the next row.
      configure(FMT_PALETTE, 13'd10, 13'd3, 15'd4, 24'h123456, 24'hFFFFFF, 1'b0, 8'hF0);
      send_byte(8'h00); send_byte(8'hA5); send_byte(8'hFF); send_byte(8'h00);
      send_byte(8'h5A); send_byte(8'h3C);

      // Saturated width, zero height, one-byte stride and a single-entry palette.
      configure(FMT_PALETTE, 13'd8191, 13'd0, 15'd1, 24'hFFFFFF, 24'h000000, 1'b1, 8'h00);
      send_byte(8'hFF);

      // 32-bit pixels with source alpha, odd height.
      configure(FMT_BGRA, 13'd2, 13'd5, 15'd8, 24'h0, 24'hFFFFFF, 1'b0, 8'd240);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h7F); send_byte(8'h80);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00);

      // Unused format code only advances the position.
      configure(FMT_UNUSED, 13'd4, 13'd4, 15'd2, 24'h0, 24'hFFFFFF, 1'b0, 8'd240);
      send_byte(8'h11); send_byte(8'h22);

      while (random_bytes < RANDOM_BYTES) begin
         sel = $urandom_range(0, 15);
         fmt = (sel < 5) ? FMT_PALETTE : (sel < 10) ? FMT_BGR : (sel < 15) ? FMT_BGRA : FMT_UNUSED;
         case ($urandom_range(0, 9))
            0: w = 13'd0;
            1: w = 13'd4096;
            2: w = 13'd8191;
            3: w = 13'($urandom_range(4097, 8191));
            default: w = 13'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0: h = 13'd0;
            1: h = 13'd4096;
            2: h = 13'd8191;
            default: h = 13'($urandom_range(1, 9));
         endcase
         case ($urandom_range(0, 9))
            0: stride = 15'd0;
            1: stride = 15'd16384;
            2: stride = 15'd32767;
            default: stride = 15'($urandom_range(1, 24));
         endcase
         p0 = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
         p1 = ($urandom_range(0, 3) == 0) ? 24'hF8F8F8 : 24'($urandom);
         one_entry = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: thr = 8'h00;
            1: thr = 8'hFF;
            2: thr = 8'hF0;
            default: thr = 8'($urandom);
         endcase
         configure(fmt, w, h, stride, p0, p1, one_entry, thr);
         n = $urandom_range(10, 40);
         for (int i = 0; i < n; i++) begin
            if (phase_no % 3 == 0 && i == n / 2) wait_drain();
            send_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'hF0, 8'hFF))
                                                  : 8'($urandom));
         end
         if (fmt != FMT_UNUSED) random_bytes += n;
         phase_no++;
      end

      wait_drain();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
